[rtl/wsd_pkg.sv]
// Shared constants, types and constant tables of the window standard deviation
// settling detector. No dependencies; every other file takes names from here.
`default_nettype none

package wsd_pkg;

    // Window geometry and sample width
    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);

    // Port field widths
    localparam int IN_SAMPLE_W = 24;
    localparam int MEAN_W      = 28;
    localparam int TARGET_W    = 16;
    localparam int STEP_W      = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 20;

    // Datapath widths
    localparam int SUM_W    = SAMPLE_BITS + IDX_W;
    localparam int SQ_W     = 2 * SAMPLE_BITS + IDX_W;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int LHS_W    = SQ_W + IDX_W;
    localparam int RHS_W    = PROD_W + 1;
    localparam int TSQ_W    = 2 * TARGET_W;
    localparam int LIM_W    = TSQ_W + 2 * IDX_W;
    localparam int STEPSQ_W = 2 * STEP_W;
    localparam int RAMP_W   = STEP_W + IDX_W;
    localparam int RC_W     = RAMP_W + SAMPLE_BITS;
    localparam int T1_W     = 2 * IDX_W;
    localparam int T2_W     = 3 * IDX_W;

    // Cycles the derived constants need after a register write or reset
    localparam int BUSY_W      = 2;
    localparam int PREP_CYCLES = 2;

    // Operation codes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STDEV = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_STEP  = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(10);
    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(1000);

    localparam logic [SAMPLE_BITS-1:0]   SAMPLE_MAX    = '1;
    localparam logic [2*SAMPLE_BITS-1:0] SAMPLE_MAX_SQ =
        (2 * SAMPLE_BITS)'(SAMPLE_MAX) * (2 * SAMPLE_BITS)'(SAMPLE_MAX);

    // Sum of j and of j*j for j below k, k = 0..WINDOW
    typedef logic [T1_W-1:0] lin_tab_t  [WINDOW+1];
    typedef logic [T2_W-1:0] quad_tab_t [WINDOW+1];

    function automatic lin_tab_t build_lin_tab();
        lin_tab_t tab;
        int acc;
        acc = 0;
        for (int k = 0; k <= WINDOW; k++)
        begin
            tab[k] = T1_W'(acc);
            acc    = acc + k;
        end
        return tab;
    endfunction

    function automatic quad_tab_t build_quad_tab();
        quad_tab_t tab;
        int acc;
        acc = 0;
        for (int k = 0; k <= WINDOW; k++)
        begin
            tab[k] = T2_W'(acc);
            acc    = acc + k * k;
        end
        return tab;
    endfunction

    localparam lin_tab_t  LIN_TAB  = build_lin_tab();
    localparam quad_tab_t QUAD_TAB = build_quad_tab();

    // Load and shift strobes for the row of window cells
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // Register values and the constants derived from them
    typedef struct packed {
        logic                busy;
        logic [STEP_W-1:0]   step;
        logic [SUM_W-1:0]    init_sum;
        logic [SQ_W-1:0]     init_sq;
        logic [LIM_W-1:0]    lim;
    } consts_t;

endpackage

`default_nettype wire

[rtl/wsd_if.sv]
// Channel interfaces of the settling detector: input items, results and the
// register write channel. Depends on wsd_pkg for field widths.
`default_nettype none

interface wsd_item_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [wsd_pkg::IN_SAMPLE_W-1:0]   sample;

    modport source (output valid, operation, sample, input ready);
    modport sink   (input valid, operation, sample, output ready);
endinterface

interface wsd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          running;
    logic                          settled;
    logic [wsd_pkg::MEAN_W-1:0]    held_mean_x16;

    modport source (output valid, running, settled, held_mean_x16, input ready);
    modport sink   (input valid, running, settled, held_mean_x16, output ready);
endinterface

interface wsd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wsd_pkg::CFG_IDX_W-1:0]     index;
    logic [wsd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/wsd_cell.sv]
// One window cell: holds a sample, passes it to its neighbor on a shift and
// loads its saturated ramp value on a start. Depends on wsd_pkg.
`default_nettype none

module wsd_cell (
    input  logic                              clk,
    input  wsd_pkg::cell_ctl_t                ctl,
    input  logic [wsd_pkg::IDX_W-1:0]         idx,
    input  logic [wsd_pkg::STEP_W-1:0]        step,
    input  logic [wsd_pkg::SAMPLE_BITS-1:0]   din,
    output logic [wsd_pkg::SAMPLE_BITS-1:0]   dout
);

    logic [wsd_pkg::RAMP_W-1:0]      ramp_full;
    logic [wsd_pkg::SAMPLE_BITS-1:0] ramp_val;
    logic [wsd_pkg::SAMPLE_BITS-1:0] val_reg;
    logic [wsd_pkg::SAMPLE_BITS-1:0] val_next;

    assign ramp_full = wsd_pkg::RAMP_W'(idx) * wsd_pkg::RAMP_W'(step);

    // Clamp the ramp to the largest sample
    assign ramp_val = (wsd_pkg::RC_W'(ramp_full) > wsd_pkg::RC_W'(wsd_pkg::SAMPLE_MAX))
                    ? wsd_pkg::SAMPLE_MAX
                    : wsd_pkg::SAMPLE_BITS'(ramp_full);

    always_comb
    begin
        val_next = val_reg;
        if (ctl.load)
        begin
            val_next = ramp_val;
        end
        else if (ctl.shift)
        begin
            val_next = din;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign dout = val_reg;

endmodule

`default_nettype wire

[rtl/wsd_prep.sv]
// Register file and derived constants: the start sums of the ramp window and
// the scaled target limit, built from registered squares. Depends on wsd_pkg, wsd_if.
`default_nettype none

module wsd_prep (
    input  logic              clk,
    input  logic              rst_n,
    wsd_cfg_if.sink           cfg,
    output wsd_pkg::consts_t  consts
);

    logic [wsd_pkg::TARGET_W-1:0] target_reg, target_next;
    logic [wsd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [wsd_pkg::BUSY_W-1:0]   busy_reg, busy_next;

    logic [wsd_pkg::CNT_W-1:0]    cnt;
    logic [wsd_pkg::CNT_W-1:0]    cnt_reg;
    logic [wsd_pkg::STEPSQ_W-1:0] step_sq_reg;
    logic [wsd_pkg::TSQ_W-1:0]    target_sq_reg;
    logic [wsd_pkg::SUM_W-1:0]    init_sum_reg;
    logic [wsd_pkg::SQ_W-1:0]     init_sq_reg;
    logic [wsd_pkg::LIM_W-1:0]    lim_reg;
    logic [wsd_pkg::CNT_W-1:0]    sat_cnt;
    logic                         write;

    assign cfg.ready = 1'b1;
    assign write     = cfg.valid && cfg.ready;

    always_comb
    begin
        target_next = target_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        if (busy_reg != '0)
        begin
            busy_next = busy_reg - 1'b1;
        end
        if (write)
        begin
            busy_next = wsd_pkg::BUSY_W'(wsd_pkg::PREP_CYCLES);
            case (cfg.index)
                wsd_pkg::REG_TARGET_STDEV: target_next = wsd_pkg::TARGET_W'(cfg.data);
                wsd_pkg::REG_PRESET_STEP:  step_next   = wsd_pkg::STEP_W'(cfg.data);
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= wsd_pkg::TARGET_RESET;
            step_reg   <= wsd_pkg::STEP_RESET;
            busy_reg   <= wsd_pkg::BUSY_W'(wsd_pkg::PREP_CYCLES);
        end
        else
        begin
            target_reg <= target_next;
            step_reg   <= step_next;
            busy_reg   <= busy_next;
        end
    end

    // Count ramp slots that do not exceed the sample ceiling
    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < wsd_pkg::WINDOW; i++)
        begin
            if (wsd_pkg::RC_W'(wsd_pkg::RAMP_W'(i) * wsd_pkg::RAMP_W'(step_reg))
                <= wsd_pkg::RC_W'(wsd_pkg::SAMPLE_MAX))
            begin
                cnt = cnt + 1'b1;
            end
        end
    end

    assign sat_cnt = wsd_pkg::CNT_W'(wsd_pkg::WINDOW) - cnt_reg;

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt;
        step_sq_reg   <= wsd_pkg::STEPSQ_W'(step_reg) * wsd_pkg::STEPSQ_W'(step_reg);
        target_sq_reg <= wsd_pkg::TSQ_W'(target_reg) * wsd_pkg::TSQ_W'(target_reg);
        init_sum_reg  <= wsd_pkg::SUM_W'(
                             wsd_pkg::SUM_W'(step_reg)
                             * wsd_pkg::SUM_W'(wsd_pkg::LIN_TAB[cnt_reg])
                           + wsd_pkg::SUM_W'(sat_cnt) * wsd_pkg::SUM_W'(wsd_pkg::SAMPLE_MAX));
        init_sq_reg   <= wsd_pkg::SQ_W'(
                             wsd_pkg::SQ_W'(step_sq_reg)
                             * wsd_pkg::SQ_W'(wsd_pkg::QUAD_TAB[cnt_reg])
                           + wsd_pkg::SQ_W'(sat_cnt) * wsd_pkg::SQ_W'(wsd_pkg::SAMPLE_MAX_SQ));
        lim_reg       <= wsd_pkg::LIM_W'(target_sq_reg)
                       * wsd_pkg::LIM_W'(wsd_pkg::WINDOW * wsd_pkg::WINDOW);
    end

    assign consts.busy     = (busy_reg != '0);
    assign consts.step     = step_reg;
    assign consts.init_sum = init_sum_reg;
    assign consts.init_sq  = init_sq_reg;
    assign consts.lim      = lim_reg;

endmodule

`default_nettype wire

[rtl/window_stddev_settle_detector_unit.sv]
// Top level of the window standard deviation settling detector: cell row,
// running-sum pipeline, settle test and result register. Depends on wsd_pkg,
// wsd_if, wsd_cell and wsd_prep.
`default_nettype none

// The detector takes one beat per clock unless busy or stalled by the result
// side, and returns one result beat for each via stages 1 to 3 and the result
// register. The window is a row of cells that shifts on every sample beat, so
// the oldest sample always falls out of the tail; a start beat loads the ramp
// into every cell at once. Running sum and sum of squares accumulate in the
// stage 2 registers; the variance test (window * sum_sq against sum^2 plus
// window^2 * target^2) is registered after its multiplier, and the armed flag
// with the held sum resolves once per beat in order at the result register.
// Samples shift through the window even while the detector is disarmed; a
// start rewrites every cell, so that data is never used. After reset and after
// each register write, the input holds ready low while the start sums and the
// target limit are recomputed. Result backpressure fills the three pipeline
// stages and the result register, four beats in all, before the input stalls.
module window_stddev_settle_detector_unit (
    input  logic              clk,
    input  logic              rst_n,
    wsd_item_if.sink          item,
    wsd_result_if.source      result,
    wsd_cfg_if.sink           cfg
);

    wsd_pkg::consts_t   consts;
    wsd_pkg::cell_ctl_t cell_ctl;

    logic                            accept;
    logic [wsd_pkg::SAMPLE_BITS-1:0] sample_in;
    logic [wsd_pkg::SAMPLE_BITS-1:0] cell_data [wsd_pkg::WINDOW];
    logic [wsd_pkg::SAMPLE_BITS-1:0] tail;

    // ---------------------------------------------------------------------
    // Stage handshake: advance a stage when the one after it is free
    // ---------------------------------------------------------------------
    logic s1_v_reg, s1_v_next;
    logic s2_v_reg, s2_v_next;
    logic s3_v_reg, s3_v_next;
    logic out_v_reg, out_v_next;
    logic out_free, s3_free, s2_free, s1_free;
    logic ld_out, ld_s3, ld_s2;

    assign out_free = !out_v_reg || result.ready;
    assign ld_out   = s3_v_reg && out_free;
    assign s3_free  = !s3_v_reg || out_free;
    assign ld_s3    = s2_v_reg && s3_free;
    assign s2_free  = !s2_v_reg || s3_free;
    assign ld_s2    = s1_v_reg && s2_free;
    assign s1_free  = !s1_v_reg || s2_free;

    assign item.ready = s1_free && !consts.busy;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        s1_v_next  = accept ? 1'b1 : (ld_s2 ? 1'b0 : s1_v_reg);
        s2_v_next  = ld_s2  ? 1'b1 : (ld_s3 ? 1'b0 : s2_v_reg);
        s3_v_next  = ld_s3  ? 1'b1 : (ld_out ? 1'b0 : s3_v_reg);
        out_v_next = ld_out ? 1'b1 : (result.ready ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            s3_v_reg  <= s3_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // ---------------------------------------------------------------------
    // Register file and derived constants
    // ---------------------------------------------------------------------
    wsd_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .consts (consts)
    );

    // ---------------------------------------------------------------------
    // Window cell row: head takes the new sample, tail drops the oldest.
    // The tail cell holds ramp slot 0, so samples replace slots in order.
    // ---------------------------------------------------------------------
    assign sample_in      = wsd_pkg::SAMPLE_BITS'(item.sample);
    assign cell_ctl.load  = accept && (item.operation == wsd_pkg::OP_START);
    assign cell_ctl.shift = accept && (item.operation == wsd_pkg::OP_SAMPLE);

    for (genvar k = 0; k < wsd_pkg::WINDOW; k++)
    begin : g_cell
        wsd_cell u_cell (
            .clk  (clk),
            .ctl  (cell_ctl),
            .idx  (wsd_pkg::IDX_W'(wsd_pkg::WINDOW - 1 - k)),
            .step (consts.step),
            .din  ((k == 0) ? sample_in : cell_data[(k == 0) ? 0 : k - 1]),
            .dout (cell_data[k])
        );
    end

    assign tail = cell_data[wsd_pkg::WINDOW-1];

    // ---------------------------------------------------------------------
    // Stage 1: square the incoming and the dropped sample
    // ---------------------------------------------------------------------
    logic                              s1_op_reg;
    logic [wsd_pkg::SAMPLE_BITS-1:0]   s1_new_reg;
    logic [wsd_pkg::SAMPLE_BITS-1:0]   s1_old_reg;
    logic [2*wsd_pkg::SAMPLE_BITS-1:0] s1_new_sq_reg;
    logic [2*wsd_pkg::SAMPLE_BITS-1:0] s1_old_sq_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= item.operation;
            s1_new_reg    <= sample_in;
            s1_old_reg    <= tail;
            s1_new_sq_reg <= (2 * wsd_pkg::SAMPLE_BITS)'(sample_in)
                           * (2 * wsd_pkg::SAMPLE_BITS)'(sample_in);
            s1_old_sq_reg <= (2 * wsd_pkg::SAMPLE_BITS)'(tail)
                           * (2 * wsd_pkg::SAMPLE_BITS)'(tail);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: running sums; these registers hold between beats and so
    // double as the accumulators
    // ---------------------------------------------------------------------
    logic                       s2_op_reg;
    logic [wsd_pkg::SUM_W-1:0]  s2_sum_reg, s2_sum_next;
    logic [wsd_pkg::SQ_W-1:0]   s2_sq_reg, s2_sq_next;

    always_comb
    begin
        if (s1_op_reg == wsd_pkg::OP_START)
        begin
            s2_sum_next = consts.init_sum;
            s2_sq_next  = consts.init_sq;
        end
        else
        begin
            s2_sum_next = s2_sum_reg - wsd_pkg::SUM_W'(s1_old_reg)
                        + wsd_pkg::SUM_W'(s1_new_reg);
            s2_sq_next  = s2_sq_reg - wsd_pkg::SQ_W'(s1_old_sq_reg)
                        + wsd_pkg::SQ_W'(s1_new_sq_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_s2)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_sum_reg <= s2_sum_next;
            s2_sq_reg  <= s2_sq_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: scale the square sum, square the sum
    // ---------------------------------------------------------------------
    logic                        s3_op_reg;
    logic [wsd_pkg::SUM_W-1:0]   s3_sum_reg;
    logic [wsd_pkg::LHS_W-1:0]   s3_lhs_reg;
    logic [wsd_pkg::PROD_W-1:0]  s3_prod_reg;

    always_ff @(posedge clk)
    begin
        if (ld_s3)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_sum_reg  <= s2_sum_reg;
            s3_lhs_reg  <= wsd_pkg::LHS_W'(s2_sq_reg) * wsd_pkg::LHS_W'(wsd_pkg::WINDOW);
            s3_prod_reg <= wsd_pkg::PROD_W'(s2_sum_reg) * wsd_pkg::PROD_W'(s2_sum_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Result stage: settle test, armed flag and held sum, in beat order
    // ---------------------------------------------------------------------
    logic                       armed_reg, armed_next;
    logic [wsd_pkg::SUM_W-1:0]  held_reg, held_next;
    logic                       out_running_reg, out_running_next;
    logic                       out_settled_reg, out_settled_next;
    logic [wsd_pkg::SUM_W-1:0]  out_held_reg;
    logic [wsd_pkg::RHS_W-1:0]  rhs;
    logic                       in_target;

    assign rhs       = wsd_pkg::RHS_W'(s3_prod_reg) + wsd_pkg::RHS_W'(consts.lim);
    assign in_target = !(wsd_pkg::RHS_W'(s3_lhs_reg) > rhs);

    always_comb
    begin
        armed_next       = armed_reg;
        held_next        = held_reg;
        out_settled_next = 1'b0;
        if (s3_op_reg == wsd_pkg::OP_START)
        begin
            armed_next = 1'b1;
            held_next  = '0;
        end
        else if (armed_reg && in_target)
        begin
            // Window is inside the target: hold the sum and disarm
            armed_next       = 1'b0;
            held_next        = s3_sum_reg;
            out_settled_next = 1'b1;
        end
        out_running_next = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            held_reg  <= '0;
        end
        else if (ld_out)
        begin
            armed_reg <= armed_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_running_reg <= out_running_next;
            out_settled_reg <= out_settled_next;
            out_held_reg    <= held_next;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.running       = out_running_reg;
    assign result.settled       = out_settled_reg;
    assign result.held_mean_x16 = wsd_pkg::MEAN_W'(out_held_reg);

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_accept_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        consts.busy |-> !item.ready)
        else $error("input accepted while derived constants recompute");

    a_accept_fills_stage1: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> s1_v_reg)
        else $error("accepted beat did not enter the first stage");

    a_ignored_sample_keeps_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ld_out && (s3_op_reg == wsd_pkg::OP_SAMPLE) && !armed_reg)
        |=> ($stable(held_reg) && !armed_reg))
        else $error("sample while disarmed changed the held sum or armed flag");

    a_settle_disarms: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ld_out && out_settled_next) |=> (!armed_reg && out_settled_reg && !out_running_reg))
        else $error("settling beat left the detector armed");

endmodule

`default_nettype wire
